>>> hw/rtl/integer_stack_with_search_assert.svh
// Assertion macros used by the bound checker, isws_check.sv.
`ifndef INTEGER_STACK_WITH_SEARCH_ASSERT_SVH
`define INTEGER_STACK_WITH_SEARCH_ASSERT_SVH

// Check a consequence in the same cycle as its trigger.
`define ISWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack check failed");

// Check a consequence in the cycle after its trigger.
`define ISWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack check failed");

`endif

>>> hw/rtl/isws_pkg.sv
package isws_pkg;

    localparam int DEPTH_DEFAULT = 256;

    localparam int         CAP_W     = 9;
    localparam logic [8:0] CAP_RESET = 9'd256;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_CLEAR  = 3'd3;
    localparam logic [2:0] OP_SEARCH = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] data;
        logic [7:0]         found_index;
        logic [8:0]         count;
        logic               is_empty;
        logic               is_full;
    } result_t;

endpackage

>>> hw/rtl/integer_stack_with_search.sv
// Bounded LIFO stack of 32-bit signed words held in one synchronous RAM of
// DEPTH entries. A transaction is accepted when start is high and busy is
// low; its result appears on result with done high for exactly one cycle,
// and cannot be stalled. Push, clear, refused operations and unknown codes
// finish without leaving the idle state, with the result in the cycle after
// acceptance, and the next transaction may be accepted right away. Pop and
// peek make one RAM read and then pass through S_READ. Search reads one entry
// per cycle from the top down through the single RAM read port, stopping at
// the first match or after the bottom entry, and busy stays high meanwhile.
// The usable capacity is the smaller of the capacity register and DEPTH;
// write it only while the stack is idle.
module integer_stack_with_search #(
    parameter int DEPTH = isws_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  isws_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             done,
    output isws_pkg::result_t result,
    input  logic             cfg_wen,
    input  logic [8:0]       cfg_wdata
);
    import isws_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;
    localparam int FW = (AW > 8) ? AW : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH
    } state_t;

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic signed [31:0] key_reg, key_next;
    logic               done_reg, done_next;
    result_t            result_reg, result_next;
    logic [8:0]         cap_reg;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [CW-1:0]      cnt_dec;
    logic [AW-1:0]      idx_dec;
    logic [MW-1:0]      usable_cap;
    logic [MW-1:0]      cap_ext;
    logic [MW-1:0]      count_ext;
    logic [MW-1:0]      count_next_ext;
    logic [FW-1:0]      found_ext;
    logic [1:0]         res_status;
    logic signed [31:0] res_data;
    logic [AW-1:0]      res_found;

    assign cnt_dec    = count_reg - CW'(1);
    assign idx_dec    = idx_reg - AW'(1);
    assign cap_ext    = MW'(cap_reg);
    assign usable_cap = (cap_ext > MW'(DEPTH)) ? MW'(DEPTH) : cap_ext;
    assign count_ext  = MW'(count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = idx_dec;
        wr_en       = 1'b0;
        res_status  = ST_OK;
        res_data    = '0;
        res_found   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.operation)
                        OP_PUSH:
                        begin
                            done_next = 1'b1;
                            if (count_ext >= usable_cap)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next  = 1'b1;
                                res_status = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cnt_dec[AW-1:0];
                                state_next = S_READ;
                                if (cmd.operation == OP_POP)
                                begin
                                    count_next = cnt_dec;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next  = 1'b1;
                                res_status = ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = cnt_dec[AW-1:0];
                                idx_next   = cnt_dec[AW-1:0];
                                key_next   = cmd.value;
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                done_next  = 1'b1;
                res_data   = rd_data_reg;
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                if (rd_data_reg == key_reg)
                begin
                    done_next  = 1'b1;
                    res_found  = idx_reg;
                    state_next = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    res_status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_dec;
                    idx_next = idx_dec;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next_ext = MW'(count_next);
        found_ext      = FW'(res_found);
        if (done_next)
        begin
            result_next.status      = res_status;
            result_next.data        = res_data;
            result_next.found_index = found_ext[7:0];
            result_next.count       = count_next_ext[8:0];
            result_next.is_empty    = (count_next == '0);
            result_next.is_full     = (count_next_ext >= usable_cap);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_wen)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/isws_check.sv
`include "integer_stack_with_search_assert.svh"

module isws_check (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input isws_pkg::result_t result
);
    import isws_pkg::*;

    `ISWS_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy)
    `ISWS_ASSERT_NOW(a_empty_flag, done, result.is_empty == (result.count == 9'd0))
    `ISWS_ASSERT_NOW(a_refused_push_full, done && result.status == ST_FULL, result.is_full)
    `ISWS_ASSERT_NOW(a_refused_no_data, done && result.status != ST_OK,
        result.data == 32'sd0 && result.found_index == 8'd0)
    `ISWS_ASSERT_NOW(a_empty_status, done && result.status == ST_EMPTY, result.is_empty)

endmodule

bind integer_stack_with_search isws_check u_isws_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> test/stack_result_checker.sv
`timescale 1ns / 100ps

module stack_result_checker #(
    parameter int DEPTH = isws_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  isws_pkg::cmd_t    cmd,
    input  logic              busy,
    input  logic              done,
    input  isws_pkg::result_t result,
    input  logic              cfg_wen,
    input  logic [8:0]        cfg_wdata,
    output int                mismatches,
    output int                outstanding
);

    import isws_pkg::*;

    logic signed [31:0] stack_mem [DEPTH];
    int                 held;
    logic [8:0]         cap_reg;
    int                 error_count;
    result_t            expected_results [$];

    function automatic int usable_capacity();
        return (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    endfunction

    function automatic result_t stack_predict(input cmd_t c);
        result_t r;
        int      i;
        logic    hit;
        r        = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        case (c.operation)
            OP_PUSH:
            begin
                if (held >= usable_capacity())
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    stack_mem[held] = c.value;
                    held++;
                end
            end
            OP_POP, OP_PEEK:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.data = stack_mem[held - 1];
                    if (c.operation == OP_POP)
                    begin
                        held--;
                    end
                end
            end
            OP_CLEAR:
            begin
                held = 0;
            end
            OP_SEARCH:
            begin
                for (i = held - 1; i >= 0 && !hit; i--)
                begin
                    if (stack_mem[i] == c.value)
                    begin
                        hit           = 1'b1;
                        r.found_index = i[7:0];
                    end
                end
                if (!hit)
                begin
                    r.status = ST_NOTFOUND;
                end
            end
            default:
            begin
            end
        endcase
        r.count    = held[8:0];
        r.is_empty = (held == 0);
        r.is_full  = (held >= usable_capacity());
        return r;
    endfunction

    task automatic compare_result(input result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
            begin
                $display("%0t: unexpected result status=%0d data=%0d idx=%0d count=%0d",
                         $realtime, got.status, got.data, got.found_index, got.count);
            end
        end
        else
        begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.data !== want.data ||
                got.found_index !== want.found_index || got.count !== want.count ||
                got.is_empty !== want.is_empty || got.is_full !== want.is_full)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("%0t: mismatch exp status=%0d data=%0d idx=%0d count=%0d e=%b f=%b",
                             $realtime, want.status, want.data, want.found_index,
                             want.count, want.is_empty, want.is_full);
                    $display("%0t:          got status=%0d data=%0d idx=%0d count=%0d e=%b f=%b",
                             $realtime, got.status, got.data, got.found_index,
                             got.count, got.is_empty, got.is_full);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            held        = 0;
            cap_reg     = CAP_RESET;
            error_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                compare_result(result);
            end
            if (start && !busy)
            begin
                expected_results.push_back(stack_predict(cmd));
            end
            if (cfg_wen)
            begin
                cap_reg = cfg_wdata;
            end
            mismatches  <= error_count;
            outstanding <= expected_results.size();
        end
    end

endmodule

>>> test/integer_stack_with_search_tb.sv
`timescale 1ns / 100ps

module integer_stack_with_search_tb;

    import isws_pkg::*;

    localparam logic [2:0] OP_LAST_CODE = 3'd7;

    logic    clk;
    logic    rst_n     = 1'b0;
    logic    start     = 1'b0;
    cmd_t    cmd       = '0;
    logic    busy;
    logic    done;
    result_t result;
    logic    cfg_wen   = 1'b0;
    logic [8:0] cfg_wdata = '0;
    int      fail_count;
    int      outstanding;
    int      burst_left = 0;

    integer_stack_with_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    stack_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Hold start until the transaction is taken; idle for a random gap, possibly none, between bursts.
    task automatic issue(input logic [2:0] op, input logic signed [31:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start         <= 1'b1;
        cmd.operation <= op;
        cmd.value     <= val;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [8:0] cap);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh0000_0000;
            1:       return -32'sd1;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7fff_ffff;
            4:       return 32'sh0000_0001;
            5:       return 32'sh1234_5678;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(input logic [8:0] cap, input int n,
                                input int push_pct, input int clear_pct);
        int         k;
        int         r;
        int         s;
        logic [2:0] op;
        write_capacity(cap);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            if (r < push_pct)
                op = OP_PUSH;
            else if (r < push_pct + clear_pct)
                op = OP_CLEAR;
            else if (s < 35)
                op = OP_POP;
            else if (s < 50)
                op = OP_PEEK;
            else if (s < 92)
                op = OP_SEARCH;
            else
                op = 3'($urandom_range(OP_SEARCH + 3'd1, OP_LAST_CODE));
            issue(op, pick_value());
        end
    endtask

    initial
    begin : stimulus
        int waited;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(OP_POP, 32'sd0);
        issue(OP_PEEK, 32'sd0);
        issue(OP_SEARCH, 32'sd0);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PUSH, 32'sh7fff_ffff);
        issue(OP_PUSH, -32'sd1);
        issue(OP_PUSH, 32'sd0);
        issue(OP_PUSH, 32'sh8000_0000);
        issue(OP_PEEK, 32'sd0);
        issue(OP_SEARCH, 32'sh8000_0000);
        issue(OP_SEARCH, 32'sh7fff_ffff);
        issue(OP_SEARCH, 32'sh0001_2345);
        issue(OP_POP, 32'sd0);
        issue(OP_SEARCH, 32'sh8000_0000);
        issue(OP_SEARCH + 3'd1, 32'sh5555_5555);
        issue(OP_LAST_CODE - 3'd1, -32'sd1);
        issue(OP_LAST_CODE, 32'shaaaa_aaaa);
        issue(OP_CLEAR, 32'sd0);
        issue(OP_POP, 32'sd0);
        issue(OP_PUSH, 32'sh5555_5555);
        issue(OP_PUSH, 32'shaaaa_aaaa);

        // Shrink capacity below the count held.
        write_capacity(9'd1);
        issue(OP_PUSH, 32'sd7);
        issue(OP_POP, 32'sd0);
        issue(OP_PEEK, 32'sd0);
        write_capacity(9'd0);
        issue(OP_PUSH, 32'sd7);
        issue(OP_POP, 32'sd0);

        random_phase(9'd256, 200, 45, 2);
        random_phase(9'd511, 350, 88, 0);
        random_phase(9'd0, 40, 40, 3);
        random_phase(9'd1, 80, 45, 3);
        random_phase(9'($urandom_range(2, 16)), 150, 45, 3);
        random_phase(9'd256, 200, 45, 2);

        start  <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 2000);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> integer_stack_with_search.f
+incdir+hw/rtl
hw/rtl/isws_pkg.sv
hw/rtl/integer_stack_with_search.sv
hw/rtl/isws_check.sv
test/stack_result_checker.sv
test/integer_stack_with_search_tb.sv
